// ===== design/dmac_pkg.sv =====
// ----------------------------------------------------------------------------
// dmac_pkg
// Shared types, codes and constants for the chunked DMA transfer controller.
// ----------------------------------------------------------------------------
package dmac_pkg;

    localparam int ADDR_BITS_DEF = 32;
    localparam int PADDR_W       = 3;
    localparam int PDATA_W       = 32;

    // register index, taken from paddr[2]
    localparam logic REG_WORD_SIZE_LOG = 1'b0;
    localparam logic REG_CHUNK_WORDS   = 1'b1;

    localparam logic [1:0] ABORT_NONE = 2'd0;

    typedef enum logic [2:0] {
        KIND_SETUP = 3'd0,
        KIND_START = 3'd1,
        KIND_POLL  = 3'd2,
        KIND_ABORT = 3'd3,
        KIND_QUERY = 3'd4
    } kind_t;

    typedef enum logic [3:0] {
        ST_OK       = 4'd0,
        ST_BUSY     = 4'd1,
        ST_DONE     = 4'd2,
        ST_NOTFOUND = 4'd3,
        ST_TOOSMALL = 4'd4,
        ST_NULL     = 4'd5,
        ST_ALIGN    = 4'd6,
        ST_OVERLAP  = 4'd7,
        ST_TOOBIG   = 4'd8,
        ST_BEYOND   = 4'd9,
        ST_ABORTED  = 4'd10
    } status_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [63:0] read_addr;
        logic [63:0] write_addr;
        logic [63:0] transfer_length;
        logic        auto_start;
        logic [31:0] chunk_override;
        logic [1:0]  abort_mode;
    } cmd_t;

    typedef struct packed {
        status_t     status;
        logic        chunk_valid;
        logic [31:0] chunk_src;
        logic [31:0] chunk_dst;
        logic [31:0] chunk_len;
    } result_t;

    typedef struct packed {
        logic        chunk_load;
        logic [31:0] chunk_val;
    } cfg_wr_t;

    // low address bits that must be zero for a word of 2^wsl bytes
    function automatic logic [2:0] align_mask(input logic [1:0] wsl);
        align_mask = 3'((4'd1 << wsl) - 4'd1);
    endfunction

endpackage

// ===== design/dmac_cfg.sv =====
// ----------------------------------------------------------------------------
// dmac_cfg
// APB register file: word size and default chunk size, with readback.
// ----------------------------------------------------------------------------
module dmac_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [dmac_pkg::PADDR_W-1:0]   paddr,
    input  logic [dmac_pkg::PDATA_W-1:0]   pwdata,
    output logic [dmac_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready,
    input  logic                           running,
    output logic [1:0]                     word_size_log,
    output dmac_pkg::cfg_wr_t              cfg_wr
);
    import dmac_pkg::*;

    logic [1:0]  wsl_reg, wsl_next;
    logic [31:0] chunk_words_reg, chunk_words_next;
    logic        wr_en;
    logic        reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[2];
    // writes are dropped while a transfer is running
    assign wr_en   = psel & penable & pwrite & pready & ~running;

    always_comb
    begin
        wsl_next          = wsl_reg;
        chunk_words_next  = chunk_words_reg;
        cfg_wr.chunk_load = 1'b0;
        cfg_wr.chunk_val  = pwdata;
        if (wr_en)
        begin
            case (reg_idx)
                REG_WORD_SIZE_LOG:
                begin
                    wsl_next = pwdata[1:0];
                end
                REG_CHUNK_WORDS:
                begin
                    if (pwdata != '0)
                    begin
                        chunk_words_next  = pwdata;
                        cfg_wr.chunk_load = 1'b1;
                    end
                end
                default:
                begin
                    wsl_next = wsl_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_WORD_SIZE_LOG: prdata = {30'd0, wsl_reg};
            REG_CHUNK_WORDS:   prdata = chunk_words_reg;
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wsl_reg         <= 2'd2;
            chunk_words_reg <= 32'd1;
        end
        else
        begin
            wsl_reg         <= wsl_next;
            chunk_words_reg <= chunk_words_next;
        end
    end

    assign word_size_log = wsl_reg;

endmodule

// ===== design/dmac_setup_chk.sv =====
// ----------------------------------------------------------------------------
// dmac_setup_chk
// Setup argument checks: null, alignment, overlap, range and wrap, by priority.
// ----------------------------------------------------------------------------
module dmac_setup_chk #(
    parameter int ADDR_BITS = dmac_pkg::ADDR_BITS_DEF
) (
    input  dmac_pkg::cmd_t    cmd,
    input  logic [1:0]        word_size_log,
    output dmac_pkg::status_t setup_err
);
    import dmac_pkg::*;

    logic [2:0]  amask;
    logic        is_null, is_misaligned, is_overlap, is_toobig, is_beyond;
    logic [63:0] rd_end, wr_end, addr_limit;

    assign amask = align_mask(word_size_log);

    assign is_null       = (cmd.read_addr == '0) || (cmd.write_addr == '0);
    assign is_misaligned = ((cmd.read_addr[2:0] & amask) != '0)
                        || ((cmd.write_addr[2:0] & amask) != '0)
                        || ((cmd.transfer_length[2:0] & amask) != '0);
    // forward overlap, distance taken modulo 2^64
    assign is_overlap    = (cmd.write_addr - cmd.read_addr) < cmd.transfer_length;
    assign is_toobig     = (cmd.read_addr[63:ADDR_BITS] != '0)
                        || (cmd.write_addr[63:ADDR_BITS] != '0)
                        || (cmd.transfer_length[63:32] != '0);

    // sums cannot wrap once the range check has passed
    assign addr_limit = 64'd1 << ADDR_BITS;
    assign rd_end     = cmd.read_addr + cmd.transfer_length;
    assign wr_end     = cmd.write_addr + cmd.transfer_length;
    assign is_beyond  = (rd_end > addr_limit) || (wr_end > addr_limit);

    always_comb
    begin
        if (is_null)
            setup_err = ST_NULL;
        else if (is_misaligned)
            setup_err = ST_ALIGN;
        else if (is_overlap)
            setup_err = ST_OVERLAP;
        else if (is_toobig)
            setup_err = ST_TOOBIG;
        else if (is_beyond)
            setup_err = ST_BEYOND;
        else
            setup_err = ST_OK;
    end

endmodule

// ===== design/dmac_core.sv =====
// ----------------------------------------------------------------------------
// dmac_core
// Transfer state and command decode; issues at most one chunk per setup with auto start, start or poll.
// ----------------------------------------------------------------------------
module dmac_core #(
    parameter int ADDR_BITS = dmac_pkg::ADDR_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  dmac_pkg::cmd_t    cmd,
    input  logic [1:0]        word_size_log,
    input  dmac_pkg::cfg_wr_t cfg_wr,
    output dmac_pkg::result_t res,
    output logic              running
);
    import dmac_pkg::*;

    logic                 running_reg, running_next;
    logic                 queued_reg, queued_next;
    logic [ADDR_BITS-1:0] src_reg, src_next;
    logic [ADDR_BITS-1:0] dst_reg, dst_next;
    logic [31:0]          rem_reg, rem_next;
    logic [31:0]          chunk_reg, chunk_next;

    status_t              setup_err;
    logic                 is_setup;
    logic [ADDR_BITS-1:0] eff_src, eff_dst;
    logic [31:0]          eff_rem, eff_chunk;
    logic [34:0]          chunk_bytes;
    logic [31:0]          take;
    logic [31:0]          rem_after;

    dmac_setup_chk #(
        .ADDR_BITS (ADDR_BITS)
    ) u_setup_chk (
        .cmd           (cmd),
        .word_size_log (word_size_log),
        .setup_err     (setup_err)
    );

    // a chunk issued by setup with auto start sees the freshly latched transfer
    assign is_setup  = (cmd.kind == KIND_SETUP);
    assign eff_src   = is_setup ? cmd.read_addr[ADDR_BITS-1:0] : src_reg;
    assign eff_dst   = is_setup ? cmd.write_addr[ADDR_BITS-1:0] : dst_reg;
    assign eff_rem   = is_setup ? cmd.transfer_length[31:0] : rem_reg;
    assign eff_chunk = (is_setup && cmd.chunk_override != '0) ? cmd.chunk_override
                                                              : chunk_reg;

    assign chunk_bytes = {3'd0, eff_chunk} << word_size_log;
    assign take        = (chunk_bytes > {3'd0, eff_rem}) ? eff_rem : chunk_bytes[31:0];
    assign rem_after   = eff_rem - take;

    always_comb
    begin
        running_next    = running_reg;
        queued_next     = queued_reg;
        src_next        = src_reg;
        dst_next        = dst_reg;
        rem_next        = rem_reg;
        chunk_next      = chunk_reg;
        res.status      = ST_OK;
        res.chunk_valid = 1'b0;
        res.chunk_src   = '0;
        res.chunk_dst   = '0;
        res.chunk_len   = '0;

        case (cmd.kind)
            KIND_SETUP,
            KIND_START,
            KIND_POLL:
            begin
                if (running_reg && cmd.kind != KIND_POLL)
                    res.status = ST_BUSY;
                else if (!running_reg && cmd.kind == KIND_POLL)
                    res.status = ST_BUSY;
                else if (is_setup && setup_err != ST_OK)
                    res.status = setup_err;
                else if (cmd.kind == KIND_START && !queued_reg)
                    res.status = ST_NOTFOUND;
                else
                begin
                    if (is_setup)
                    begin
                        src_next    = eff_src;
                        dst_next    = eff_dst;
                        rem_next    = eff_rem;
                        chunk_next  = eff_chunk;
                        queued_next = 1'b1;
                    end
                    if (is_setup && !cmd.auto_start)
                        res.status = ST_OK;
                    else if (eff_rem == '0)
                        res.status = ST_DONE;   // queued stays set
                    else
                    begin
                        res.chunk_valid = 1'b1;
                        res.chunk_src   = 32'(eff_src);
                        res.chunk_dst   = 32'(eff_dst);
                        res.chunk_len   = take;
                        src_next        = eff_src + ADDR_BITS'(take);
                        dst_next        = eff_dst + ADDR_BITS'(take);
                        rem_next        = rem_after;
                        if (rem_after != '0)
                        begin
                            running_next = 1'b1;
                            res.status   = ST_BUSY;
                        end
                        else
                        begin
                            running_next = 1'b0;
                            queued_next  = 1'b0;
                            res.status   = (cmd.kind == KIND_POLL) ? ST_OK : ST_DONE;
                        end
                    end
                end
            end
            KIND_ABORT:
            begin
                if (cmd.abort_mode == ABORT_NONE)
                    res.status = ST_DONE;
                else
                begin
                    running_next = 1'b0;
                    queued_next  = 1'b0;
                    res.status   = ST_ABORTED;
                end
            end
            KIND_QUERY:
            begin
                res.status = running_reg ? ST_BUSY : ST_OK;
            end
            default:
            begin
                res.status = ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg <= 1'b0;
            queued_reg  <= 1'b0;
            src_reg     <= '0;
            dst_reg     <= '0;
            rem_reg     <= '0;
            chunk_reg   <= 32'd1;
        end
        else if (cfg_wr.chunk_load)
        begin
            chunk_reg <= cfg_wr.chunk_val;
        end
        else if (fire)
        begin
            running_reg <= running_next;
            queued_reg  <= queued_next;
            src_reg     <= src_next;
            dst_reg     <= dst_next;
            rem_reg     <= rem_next;
            chunk_reg   <= chunk_next;
        end
    end

    assign running = running_reg;

endmodule

// ===== design/chunked_dma_transfer_controller.sv =====
// ----------------------------------------------------------------------------
// chunked_dma_transfer_controller
// Command-driven DMA controller issuing chunk copy commands, one result a beat.
// Path: input register, then result register. Throughput: one command per cycle
// unless a full result slot is stalled; the single decode stage sets this rate.
// Reset: asynchronous, active low; clears the transfer state, sets word size
// to 4 bytes and the chunk size to one word. No clearing pass.
// ----------------------------------------------------------------------------
module chunked_dma_transfer_controller #(
    parameter int ADDR_BITS = dmac_pkg::ADDR_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [2:0]                   kind,
    input  logic [63:0]                  read_addr,
    input  logic [63:0]                  write_addr,
    input  logic [63:0]                  transfer_length,
    input  logic                         auto_start,
    input  logic [31:0]                  chunk_override,
    input  logic [1:0]                   abort_mode,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [3:0]                   status,
    output logic                         chunk_valid,
    output logic [31:0]                  chunk_src,
    output logic [31:0]                  chunk_dst,
    output logic [31:0]                  chunk_len,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [dmac_pkg::PADDR_W-1:0] paddr,
    input  logic [dmac_pkg::PDATA_W-1:0] pwdata,
    output logic [dmac_pkg::PDATA_W-1:0] prdata,
    output logic                         pready
);
    import dmac_pkg::*;

    logic      in_valid_reg, in_valid_next;
    cmd_t      cmd_reg;
    logic      out_valid_reg, out_valid_next;
    result_t   res_reg;
    result_t   res;
    logic      fire;
    logic      running;
    logic [1:0] word_size_log;
    cfg_wr_t   cfg_wr;

    dmac_cfg u_cfg (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .running       (running),
        .word_size_log (word_size_log),
        .cfg_wr        (cfg_wr)
    );

    dmac_core #(
        .ADDR_BITS (ADDR_BITS)
    ) u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .fire          (fire),
        .cmd           (cmd_reg),
        .word_size_log (word_size_log),
        .cfg_wr        (cfg_wr),
        .res           (res),
        .running       (running)
    );

    // the input beat moves on whenever the result slot is free or being emptied
    assign fire     = in_valid_reg & ~(out_valid_reg & out_stall);
    assign in_stall = in_valid_reg & ~fire;

    always_comb
    begin
        in_valid_next = in_stall ? in_valid_reg : in_valid;
        if (fire)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall)
        begin
            cmd_reg.kind            <= kind;
            cmd_reg.read_addr       <= read_addr;
            cmd_reg.write_addr      <= write_addr;
            cmd_reg.transfer_length <= transfer_length;
            cmd_reg.auto_start      <= auto_start;
            cmd_reg.chunk_override  <= chunk_override;
            cmd_reg.abort_mode      <= abort_mode;
        end
        if (fire)
            res_reg <= res;
    end

    assign out_valid   = out_valid_reg;
    assign status      = res_reg.status;
    assign chunk_valid = res_reg.chunk_valid;
    assign chunk_src   = res_reg.chunk_src;
    assign chunk_dst   = res_reg.chunk_dst;
    assign chunk_len   = res_reg.chunk_len;

endmodule

// ===== design/dmac_checker.sv =====
// ----------------------------------------------------------------------------
// dmac_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module dmac_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_stall,
    input logic                         out_valid,
    input logic                         out_stall,
    input logic [3:0]                   status,
    input logic                         chunk_valid,
    input logic [31:0]                  chunk_src,
    input logic [31:0]                  chunk_dst,
    input logic [31:0]                  chunk_len
);
    import dmac_pkg::*;

    // a result without a chunk carries an all-zero chunk command
    a_idle_chunk_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !chunk_valid) |->
            (chunk_src == '0 && chunk_dst == '0 && chunk_len == '0))
        else $error("chunk fields nonzero without chunk_valid");

    // chunk size is never zero, so an issued chunk always moves bytes
    a_chunk_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && chunk_valid) |-> (chunk_len != '0))
        else $error("issued chunk with zero length");

    a_chunk_status: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && chunk_valid) |->
            (status == ST_OK || status == ST_BUSY || status == ST_DONE))
        else $error("chunk issued with an error status");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=>
            (out_valid && $stable(status) && $stable(chunk_valid)
             && $stable(chunk_len)))
        else $error("stalled result beat changed");

    // input only backs up behind a full, stalled result slot
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled with the result slot free");

endmodule

bind chunked_dma_transfer_controller dmac_checker u_dmac_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .chunk_valid (chunk_valid),
    .chunk_src   (chunk_src),
    .chunk_dst   (chunk_dst),
    .chunk_len   (chunk_len)
);

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: chunked DMA transfer controller
// Drives setup, start, poll, abort and busy-query commands through the
// valid/stall command channel and predicts every result beat in-line. Chunk
// commands are checked field by field against a local copy of the transfer
// state. Register settings change between phases over the APB port. Random
// idles, a long output hold-off and a drain pause exercise the handshake.
// ----------------------------------------------------------------------------
module testbench;
    import dmac_pkg::*;

    localparam int          NUM_PHASES  = 6;
    localparam int          PHASE_ITEMS = 320;
    localparam int          HOLD_CYCLES = 90;
    localparam int          CYCLE_LIMIT = 400000;
    localparam logic [63:0] ADDR_TOP    = 64'hFFFF_FFFF;
    localparam logic [63:0] ADDR_SPAN   = 64'h1_0000_0000;

    logic        clk             = 1'b0;
    logic        rst_n           = 1'b0;
    logic        in_valid        = 1'b0;
    logic        in_stall;
    logic [2:0]  kind            = '0;
    logic [63:0] read_addr       = '0;
    logic [63:0] write_addr      = '0;
    logic [63:0] transfer_length = '0;
    logic        auto_start      = 1'b0;
    logic [31:0] chunk_override  = '0;
    logic [1:0]  abort_mode      = '0;
    logic        out_valid;
    logic        out_stall       = 1'b0;
    logic [3:0]  status;
    logic        chunk_valid;
    logic [31:0] chunk_src;
    logic [31:0] chunk_dst;
    logic [31:0] chunk_len;
    logic        psel            = 1'b0;
    logic        penable         = 1'b0;
    logic        pwrite          = 1'b0;
    logic [PADDR_W-1:0] paddr    = '0;
    logic [PDATA_W-1:0] pwdata   = '0;
    logic [PDATA_W-1:0] prdata;
    logic        pready;

    chunked_dma_transfer_controller DUT (.*);

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // register settings per phase: word size extremes, chunk extremes, a dropped zero write
    logic [1:0]  ph_wsl   [NUM_PHASES] = '{2'd0, 2'd3, 2'd1, 2'd2, 2'd3, 2'd0};
    logic [31:0] ph_chunk [NUM_PHASES] = '{32'd1, 32'hFFFF_FFFF, 32'd3, 32'd0, 32'd2, 32'd7};

    cmd_t    cmd_backlog[$];
    result_t due_results[$];
    cmd_t    drv_cmd;
    result_t got;
    result_t want;

    int accepted_cnt = 0;
    int queued_cnt   = 0;
    int checked_cnt  = 0;
    int chunk_cnt    = 0;
    int err_cnt      = 0;
    int cycle_cnt    = 0;
    int hold_left    = 0;

    logic calm       = 1'b0;
    logic hold_req   = 1'b0;
    logic hold_taken = 1'b0;

    // transfer state as the controller should hold it
    logic        xfer_running = 1'b0;
    logic        xfer_queued  = 1'b0;
    logic [31:0] xfer_src     = '0;
    logic [31:0] xfer_dst     = '0;
    logic [31:0] xfer_left    = '0;
    logic [31:0] xfer_chunk   = 32'd1;
    logic [1:0]  xfer_wsl     = 2'd2;

    // generator's view of the settings, used to size poll runs
    logic [1:0]  gen_wsl;
    logic [31:0] gen_chunk;

    function automatic result_t issue_chunk(input status_t done_st);
        result_t     r;
        logic [63:0] nbytes;
        r = '0;
        nbytes = 64'(xfer_chunk) << xfer_wsl;
        if (nbytes > 64'(xfer_left))
            nbytes = 64'(xfer_left);
        r.chunk_valid = 1'b1;
        r.chunk_src   = xfer_src;
        r.chunk_dst   = xfer_dst;
        r.chunk_len   = nbytes[31:0];
        xfer_src  = xfer_src + nbytes[31:0];
        xfer_dst  = xfer_dst + nbytes[31:0];
        xfer_left = xfer_left - nbytes[31:0];
        if (xfer_left != 0)
        begin
            r.status = ST_BUSY;
        end
        else
        begin
            xfer_running = 1'b0;
            xfer_queued  = 1'b0;
            r.status     = done_st;
        end
        return r;
    endfunction

    function automatic result_t start_transfer();
        result_t r;
        r = '0;
        if (xfer_running)
            r.status = ST_BUSY;
        else if (!xfer_queued)
            r.status = ST_NOTFOUND;
        else if (xfer_left == 0)
            r.status = ST_DONE;   // zero length: nothing issued, stays queued
        else
        begin
            xfer_running = 1'b1;
            r = issue_chunk(ST_DONE);
        end
        return r;
    endfunction

    function automatic result_t dma_result_for(input cmd_t c);
        result_t     r;
        status_t     st;
        logic [63:0] amask;
        r = '0;
        r.status = ST_OK;
        case (kind_t'(c.kind))
            KIND_SETUP:
            begin
                amask = (64'd1 << xfer_wsl) - 64'd1;
                if (xfer_running)
                    st = ST_BUSY;
                else if (c.read_addr == 0 || c.write_addr == 0)
                    st = ST_NULL;
                else if (((c.read_addr | c.write_addr | c.transfer_length) & amask) != 0)
                    st = ST_ALIGN;
                else if (c.write_addr - c.read_addr < c.transfer_length)
                    st = ST_OVERLAP;
                else if (c.read_addr > ADDR_TOP || c.write_addr > ADDR_TOP
                         || c.transfer_length > ADDR_TOP)
                    st = ST_TOOBIG;
                else if (c.read_addr + c.transfer_length > ADDR_SPAN
                         || c.write_addr + c.transfer_length > ADDR_SPAN)
                    st = ST_BEYOND;
                else
                    st = ST_OK;
                if (st != ST_OK)
                begin
                    r.status = st;
                end
                else
                begin
                    if (c.chunk_override != 0)
                        xfer_chunk = c.chunk_override;
                    xfer_src    = c.read_addr[31:0];
                    xfer_dst    = c.write_addr[31:0];
                    xfer_left   = c.transfer_length[31:0];
                    xfer_queued = 1'b1;
                    if (c.auto_start)
                        r = start_transfer();
                end
            end
            KIND_START:
                r = start_transfer();
            KIND_POLL:
                if (!xfer_running)
                    r.status = ST_BUSY;
                else
                    r = issue_chunk(ST_OK);
            KIND_ABORT:
                if (c.abort_mode == ABORT_NONE)
                    r.status = ST_DONE;
                else
                begin
                    xfer_running = 1'b0;
                    xfer_queued  = 1'b0;
                    r.status     = ST_ABORTED;
                end
            KIND_QUERY:
                r.status = xfer_running ? ST_BUSY : ST_OK;
            default: ;
        endcase
        return r;
    endfunction

    function automatic cmd_t plain_cmd(input kind_t k, input logic [1:0] am);
        cmd_t c;
        c.kind            = k;
        c.read_addr       = {$urandom, $urandom};
        c.write_addr      = {$urandom, $urandom};
        c.transfer_length = {$urandom, $urandom};
        c.auto_start      = 1'($urandom_range(0, 1));
        c.chunk_override  = $urandom;
        c.abort_mode      = am;
        return c;
    endfunction

    function automatic cmd_t setup_cmd(input logic [63:0] rd, input logic [63:0] wr,
                                       input logic [63:0] len, input logic auto,
                                       input logic [31:0] ov);
        cmd_t c;
        c = plain_cmd(KIND_SETUP, 2'($urandom_range(0, 3)));
        c.read_addr       = rd;
        c.write_addr      = wr;
        c.transfer_length = len;
        c.auto_start      = auto;
        c.chunk_override  = ov;
        return c;
    endfunction

    // setup that mostly passes every check; wide ones use a large chunk to keep polls short
    function automatic cmd_t legal_setup(input logic [1:0] wsl, input logic wide);
        logic [63:0] word;
        logic [63:0] len;
        logic [63:0] span;
        logic [63:0] rd;
        logic [63:0] wr;
        logic [31:0] ov;
        int          pick;
        word = 64'd1 << wsl;
        if (wide)
            len = word * 64'($urandom_range(0, 1 << 20));
        else
            len = word * 64'($urandom_range(0, 24));
        span = (ADDR_SPAN - len) >> wsl;
        if ($urandom_range(0, 7) == 0)
            rd = span << wsl;   // ends exactly at the top of the address space
        else
            rd = ((64'($urandom) % span) + 1) << wsl;
        wr = ((64'($urandom) % span) + 1) << wsl;
        if (wr - rd < len)
            wr = ((64'($urandom) % span) + 1) << wsl;
        if ($urandom_range(0, 9) == 0 && rd + 2 * len <= ADDR_SPAN)
            wr = rd + len;      // adjacent, just clear of overlap
        pick = $urandom_range(0, 9);
        if (wide)
            ov = $urandom_range(1 << 16, 32'hFFFF_FFFF);
        else if (pick < 4)
            ov = '0;
        else if (pick < 9)
            ov = $urandom_range(1, 6);
        else
            ov = 32'hFFFF_FFFF;
        return setup_cmd(rd, wr, len, 1'($urandom_range(0, 1)), ov);
    endfunction

    task automatic queue_cmd(input cmd_t c);
        cmd_backlog.push_back(c);
        queued_cnt++;
    endtask

    // setup, optional start, polls sized from the chunk count, a query or abort here and there
    task automatic gen_transfer();
        cmd_t        c;
        logic [63:0] lenw;
        logic [63:0] chunks;
        int          npoll;
        c = legal_setup(gen_wsl, $urandom_range(0, 9) == 0);
        queue_cmd(c);
        if (c.chunk_override != 0)
            gen_chunk = c.chunk_override;
        lenw   = c.transfer_length >> gen_wsl;
        chunks = (lenw + 64'(gen_chunk) - 1) / 64'(gen_chunk);
        if (!c.auto_start && $urandom_range(0, 9) != 0)
            queue_cmd(plain_cmd(KIND_START, 2'($urandom_range(0, 3))));
        npoll = (chunks > 40) ? 40 : int'(chunks);
        npoll = npoll + $urandom_range(0, 2) - 1;
        for (int i = 0; i < npoll; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                queue_cmd(plain_cmd(KIND_QUERY, 2'($urandom_range(0, 3))));
            else
                queue_cmd(plain_cmd(KIND_POLL, 2'($urandom_range(0, 3))));
        end
        if ($urandom_range(0, 6) == 0)
            queue_cmd(plain_cmd(KIND_ABORT, 2'($urandom_range(0, 3))));
    endtask

    // a legal setup with one defect planted
    task automatic gen_bad_setup();
        cmd_t        c;
        logic [63:0] word;
        word = 64'd1 << gen_wsl;
        c = legal_setup(gen_wsl, 1'b0);
        if (c.transfer_length < 2 * word)
            c.transfer_length = c.transfer_length + 2 * word;
        case ($urandom_range(0, 4))
            0:
                if ($urandom_range(0, 1) == 0)
                    c.read_addr = '0;
                else
                    c.write_addr = '0;
            1:
                case ($urandom_range(0, 2))
                    0: c.read_addr = c.read_addr | 64'($urandom_range(1, 7));
                    1: c.write_addr = c.write_addr | 64'($urandom_range(1, 7));
                    default: c.transfer_length = c.transfer_length | 64'($urandom_range(1, 7));
                endcase
            2:
                c.write_addr = c.read_addr
                    + ((64'($urandom) % (c.transfer_length >> gen_wsl)) << gen_wsl);
            3:
                case ($urandom_range(0, 2))
                    0: c.read_addr = c.read_addr | (64'd1 << $urandom_range(32, 63));
                    1: c.write_addr = c.write_addr | (64'd1 << $urandom_range(32, 63));
                    default:
                        c.transfer_length = c.transfer_length
                            | (64'd1 << $urandom_range(32, 63));
                endcase
            default:
                if ($urandom_range(0, 1) == 0)
                    c.read_addr = ADDR_SPAN - word;
                else
                begin
                    c.write_addr = ADDR_SPAN - word;
                    c.read_addr  = word;
                end
        endcase
        queue_cmd(c);
    endtask

    task automatic cfg_write(input logic idx, input logic [31:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        // dropped while a transfer runs; a zero chunk size is refused
        if (!xfer_running)
        begin
            if (idx == REG_WORD_SIZE_LOG)
                xfer_wsl = val[1:0];
            else if (val != 0)
                xfer_chunk = val;
        end
    endtask

    task automatic wait_idle();
        while (accepted_cnt != queued_cnt || due_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // command driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                due_results.push_back(dma_result_for(drv_cmd));
                accepted_cnt++;
            end
            if (!(in_valid && in_stall))
            begin
                if (cmd_backlog.size() != 0
                    && (calm || $urandom_range(0, 99) >= 26))
                begin
                    drv_cmd          = cmd_backlog.pop_front();
                    in_valid        <= 1'b1;
                    kind            <= drv_cmd.kind;
                    read_addr       <= drv_cmd.read_addr;
                    write_addr      <= drv_cmd.write_addr;
                    transfer_length <= drv_cmd.transfer_length;
                    auto_start      <= drv_cmd.auto_start;
                    chunk_override  <= drv_cmd.chunk_override;
                    abort_mode      <= drv_cmd.abort_mode;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_cnt, due_results.size());
            $display("testbench: errors");
            $finish;
        end
        else if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                got.status      = status_t'(status);
                got.chunk_valid = chunk_valid;
                got.chunk_src   = chunk_src;
                got.chunk_dst   = chunk_dst;
                got.chunk_len   = chunk_len;
                if (due_results.size() == 0)
                begin
                    if (err_cnt < 10)
                        $display("unexpected result beat: st=%0d v=%0b src=%h dst=%h len=%h",
                                 got.status, got.chunk_valid, got.chunk_src,
                                 got.chunk_dst, got.chunk_len);
                    err_cnt++;
                end
                else
                begin
                    want = due_results.pop_front();
                    checked_cnt++;
                    if (want.chunk_valid)
                        chunk_cnt++;
                    if (got !== want)
                    begin
                        if (err_cnt < 10)
                        begin
                            $display("mismatch at result %0d: want st=%0d v=%0b src=%h dst=%h len=%h",
                                     checked_cnt, want.status, want.chunk_valid,
                                     want.chunk_src, want.chunk_dst, want.chunk_len);
                            $display("    got st=%0d v=%0b src=%h dst=%h len=%h",
                                     got.status, got.chunk_valid, got.chunk_src,
                                     got.chunk_dst, got.chunk_len);
                        end
                        err_cnt++;
                    end
                end
            end
        end
    end

    // output stall: random idles, plus one long hold-off so the input side backs up
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (hold_req && !hold_taken)
            begin
                hold_taken <= 1'b1;
                hold_left  <= HOLD_CYCLES;
                out_stall  <= 1'b1;
            end
            else if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= !calm && ($urandom_range(0, 99) < 26);
            end
        end
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: idle commands, each setup check in order, busy paths, aborts
        queue_cmd(plain_cmd(KIND_QUERY, ABORT_NONE));
        queue_cmd(plain_cmd(KIND_START, ABORT_NONE));
        queue_cmd(plain_cmd(KIND_POLL, ABORT_NONE));
        queue_cmd(setup_cmd(64'h0, 64'h2000, 64'h10, 1'b1, 32'd0));
        queue_cmd(setup_cmd(64'h1000, 64'h0, 64'h10, 1'b0, 32'd0));
        queue_cmd(setup_cmd(64'h1002, 64'h2000, 64'h10, 1'b0, 32'd0));
        queue_cmd(setup_cmd(64'h1000, 64'h2001, 64'h10, 1'b0, 32'd0));
        queue_cmd(setup_cmd(64'h1000, 64'h2000, 64'h11, 1'b0, 32'd0));
        queue_cmd(setup_cmd(64'h1000, 64'h1004, 64'h8, 1'b0, 32'd0));
        queue_cmd(setup_cmd(64'hFFFF_FFFF_FFFF_FFFC, 64'h2000, 64'h10, 1'b0, 32'd0));
        queue_cmd(setup_cmd(64'h1000, 64'h1_0000_0000, 64'h10, 1'b0, 32'd0));
        queue_cmd(setup_cmd(64'h2000, 64'h1000, 64'h1_0000_0000, 1'b0, 32'd0));
        queue_cmd(setup_cmd(64'hFFFF_FFF0, 64'h1000, 64'h20, 1'b0, 32'd0));
        queue_cmd(setup_cmd(64'h1000, 64'hFFFF_FFF0, 64'h20, 1'b0, 32'd0));
        queue_cmd(setup_cmd(64'hFFFF_FFE0, 64'h1000, 64'h20, 1'b0, 32'd0));
        queue_cmd(plain_cmd(KIND_START, ABORT_NONE));
        queue_cmd(setup_cmd(64'h100, 64'h200, 64'h10, 1'b0, 32'd0));
        queue_cmd(plain_cmd(KIND_START, ABORT_NONE));
        queue_cmd(plain_cmd(KIND_QUERY, ABORT_NONE));
        queue_cmd(plain_cmd(KIND_ABORT, ABORT_NONE));
        queue_cmd(plain_cmd(KIND_POLL, ABORT_NONE));
        queue_cmd(plain_cmd(KIND_ABORT, 2'd3));
        queue_cmd(setup_cmd(64'h100, 64'h200, 64'h0, 1'b1, 32'd0));
        queue_cmd(plain_cmd(KIND_START, ABORT_NONE));
        queue_cmd(setup_cmd(64'h4000, 64'h8000, 64'h40, 1'b1, 32'hFFFF_FFFF));
        queue_cmd(setup_cmd(64'h10, 64'h20, 64'h10, 1'b1, 32'd2));
        queue_cmd(plain_cmd(KIND_POLL, ABORT_NONE));
        queue_cmd(plain_cmd(KIND_ABORT, 2'd1));
        queue_cmd(plain_cmd(kind_t'(3'd7), ABORT_NONE));
        wait_idle();

        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            // one phase keeps any live transfer so its register writes are dropped
            if (phase != 4)
            begin
                queue_cmd(plain_cmd(KIND_ABORT, 2'd2));
                wait_idle();
            end
            cfg_write(REG_WORD_SIZE_LOG, 32'(ph_wsl[phase]));
            cfg_write(REG_CHUNK_WORDS, ph_chunk[phase]);
            gen_wsl   = xfer_wsl;
            gen_chunk = xfer_chunk;
            calm <= (phase == 3);
            if (phase == 2)
                hold_req <= 1'b1;
            while (queued_cnt < accepted_cnt + PHASE_ITEMS)
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5:
                        gen_transfer();
                    6:
                        queue_cmd(plain_cmd(kind_t'(3'($urandom_range(1, 4))),
                                            2'($urandom_range(0, 3))));
                    7, 8:
                        gen_bad_setup();
                    default:
                        queue_cmd(plain_cmd(kind_t'(3'($urandom_range(0, 7))),
                                            2'($urandom_range(0, 3))));
                endcase
            end
            wait_idle();
        end

        repeat (8) @(posedge clk);
        $display("covered %0d commands over %0d register settings", accepted_cnt,
                 NUM_PHASES + 1);
        $display("checked %0d result beats, %0d of them chunk commands, %0d errors",
                 checked_cnt, chunk_cnt, err_cnt);
        if (err_cnt == 0 && due_results.size() == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
